// ----- sv/gsbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gsbs_pkg
// Shared types and constants for the golden-section bracket search core.
// ----------------------------------------------------------------------------
package gsbs_pkg;

  // Default word width of positions and function values (Q16.16).
  localparam int DEF_DATA_WIDTH = 32;

  // Tolerance registers are 16 bits wide.
  localparam int TOL_WIDTH = 16;

  // Golden-section fraction 0.381966011250105 as unsigned Q0.32.
  localparam int GOLD_WIDTH = 32;
  localparam logic [GOLD_WIDTH-1:0] GOLD_Q32 = 32'h61C8_8647;

  // Configuration port geometry: three 32-bit registers at 4-byte spacing.
  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  localparam logic [TOL_WIDTH-1:0] REL_TOL_RESET     = 16'd256;
  localparam logic [TOL_WIDTH-1:0] MIN_REL_TOL_RESET = 16'd16;
  localparam logic [TOL_WIDTH-1:0] ABS_TOL_RESET     = 16'd16;

  typedef enum logic [1:0] {
    REG_REL_TOL     = 2'd0,
    REG_MIN_REL_TOL = 2'd1,
    REG_ABS_TOL     = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PROBE = 1'b1
  } op_t;

  typedef struct packed {
    logic [TOL_WIDTH-1:0] rel_tolerance;
    logic [TOL_WIDTH-1:0] min_rel_tolerance;
    logic [TOL_WIDTH-1:0] abs_tolerance;
  } cfg_t;

  // Search status carried from one word to the next.
  typedef struct packed {
    logic searching;
    logic on_right;
  } flags_t;

endpackage

// ----- sv/gsbs_regs.sv -----
// ----------------------------------------------------------------------------
// gsbs_regs
// APB-style register file holding the three stopping tolerances.
// ----------------------------------------------------------------------------
module gsbs_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gsbs_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [gsbs_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [gsbs_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  output gsbs_pkg::cfg_t                       cfg
);

  logic [1:0] index;

  assign index  = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rel_tolerance     <= gsbs_pkg::REL_TOL_RESET;
      cfg.min_rel_tolerance <= gsbs_pkg::MIN_REL_TOL_RESET;
      cfg.abs_tolerance     <= gsbs_pkg::ABS_TOL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (gsbs_pkg::reg_index_t'(index))
        gsbs_pkg::REG_REL_TOL:     cfg.rel_tolerance     <= pwdata[gsbs_pkg::TOL_WIDTH-1:0];
        gsbs_pkg::REG_MIN_REL_TOL: cfg.min_rel_tolerance <= pwdata[gsbs_pkg::TOL_WIDTH-1:0];
        gsbs_pkg::REG_ABS_TOL:     cfg.abs_tolerance     <= pwdata[gsbs_pkg::TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (gsbs_pkg::reg_index_t'(index))
      gsbs_pkg::REG_REL_TOL:     prdata = gsbs_pkg::APB_DATA_WIDTH'(cfg.rel_tolerance);
      gsbs_pkg::REG_MIN_REL_TOL: prdata = gsbs_pkg::APB_DATA_WIDTH'(cfg.min_rel_tolerance);
      gsbs_pkg::REG_ABS_TOL:     prdata = gsbs_pkg::APB_DATA_WIDTH'(cfg.abs_tolerance);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- sv/gsbs_update.sv -----
// ----------------------------------------------------------------------------
// gsbs_update
// Loads and sorts a new bracket, or folds a probe value into the current one.
// ----------------------------------------------------------------------------
module gsbs_update #(
  parameter int DATA_WIDTH = gsbs_pkg::DEF_DATA_WIDTH
) (
  input  logic                          operation,
  input  logic signed [DATA_WIDTH-1:0]  start_pos [3],
  input  logic signed [DATA_WIDTH-1:0]  start_val [3],
  input  logic signed [DATA_WIDTH-1:0]  probe_value,
  input  logic signed [DATA_WIDTH-1:0]  pos_cur [3],
  input  logic signed [DATA_WIDTH-1:0]  val_cur [3],
  input  logic signed [DATA_WIDTH-1:0]  probe_point,
  input  gsbs_pkg::flags_t              flags_cur,
  output logic signed [DATA_WIDTH-1:0]  pos_next [3],
  output logic signed [DATA_WIDTH-1:0]  val_next [3],
  output logic                          idle_probe
);

  logic signed [DATA_WIDTH-1:0] p [3];
  logic signed [DATA_WIDTH-1:0] v [3];
  logic signed [DATA_WIDTH-1:0] t;
  logic                         not_lower;

  // Compare-swap network: (0,1), (1,2), (0,1). Equal positions keep order.
  always_comb begin
    p = pos_cur;
    v = val_cur;
    t = '0;
    idle_probe = 1'b0;
    not_lower = (probe_value >= val_cur[1]);
    if (operation == gsbs_pkg::OP_START) begin
      p = start_pos;
      v = start_val;
      if (p[0] > p[1]) begin
        t = p[0]; p[0] = p[1]; p[1] = t;
        t = v[0]; v[0] = v[1]; v[1] = t;
      end
      if (p[1] > p[2]) begin
        t = p[1]; p[1] = p[2]; p[2] = t;
        t = v[1]; v[1] = v[2]; v[2] = t;
      end
      if (p[0] > p[1]) begin
        t = p[0]; p[0] = p[1]; p[1] = t;
        t = v[0]; v[0] = v[1]; v[1] = t;
      end
    end else if (flags_cur.searching) begin
      if (flags_cur.on_right) begin
        if (not_lower) begin
          p[2] = probe_point;
          v[2] = probe_value;
        end else begin
          p[0] = pos_cur[1];
          v[0] = val_cur[1];
          p[1] = probe_point;
          v[1] = probe_value;
        end
      end else begin
        if (not_lower) begin
          p[0] = probe_point;
          v[0] = probe_value;
        end else begin
          p[2] = pos_cur[1];
          v[2] = val_cur[1];
          p[1] = probe_point;
          v[1] = probe_value;
        end
      end
    end else begin
      idle_probe = 1'b1;
    end
  end

  assign pos_next = p;
  assign val_next = v;

endmodule

// ----- sv/gsbs_decide.sv -----
// ----------------------------------------------------------------------------
// gsbs_decide
// Convergence test and golden-section probe placement for a sorted bracket.
// ----------------------------------------------------------------------------
module gsbs_decide #(
  parameter int DATA_WIDTH = gsbs_pkg::DEF_DATA_WIDTH
) (
  input  logic signed [DATA_WIDTH-1:0]  pos [3],
  input  gsbs_pkg::cfg_t                cfg,
  output logic signed [DATA_WIDTH-1:0]  probe,
  output gsbs_pkg::flags_t              flags
);

  localparam int TW = gsbs_pkg::TOL_WIDTH;
  localparam int GW = gsbs_pkg::GOLD_WIDTH;

  logic [DATA_WIDTH-1:0]    width, ab, bc, mag, side, rel_thr, floor_thr, gpart;
  logic [DATA_WIDTH-1:0]    abs_thr, probe_raw;
  logic [TW-1:0]            tol;
  logic [DATA_WIDTH+TW-1:0] rel_prod;
  logic [DATA_WIDTH+GW-1:0] gold_prod;

  assign width = DATA_WIDTH'(pos[2] - pos[0]);
  assign ab    = DATA_WIDTH'(pos[1] - pos[0]);
  assign bc    = DATA_WIDTH'(pos[2] - pos[1]);
  assign mag   = pos[1][DATA_WIDTH-1] ? DATA_WIDTH'(-pos[1]) : DATA_WIDTH'(pos[1]);

  // Relative threshold: floor(|middle| * max(rel, min_rel) / 2^16).
  assign tol      = (cfg.rel_tolerance > cfg.min_rel_tolerance) ?
                    cfg.rel_tolerance : cfg.min_rel_tolerance;
  assign rel_prod = (DATA_WIDTH+TW)'(mag) * (DATA_WIDTH+TW)'(tol);
  assign rel_thr  = rel_prod[DATA_WIDTH+TW-1:TW];
  assign abs_thr  = DATA_WIDTH'(cfg.abs_tolerance);
  assign floor_thr = (abs_thr > rel_thr) ? abs_thr : rel_thr;

  // The right side is taken only when strictly wider; the offset is rounded
  // to nearest with ties up.
  assign flags.on_right  = (bc > ab);
  assign flags.searching = (width > floor_thr);
  assign side      = flags.on_right ? bc : ab;
  assign gold_prod = (DATA_WIDTH+GW)'(side) * (DATA_WIDTH+GW)'(gsbs_pkg::GOLD_Q32);
  assign gpart     = gold_prod[DATA_WIDTH+GW-1:GW] + DATA_WIDTH'(gold_prod[GW-1]);
  assign probe_raw = flags.on_right ? DATA_WIDTH'(pos[1]) + gpart
                                    : DATA_WIDTH'(pos[1]) - gpart;
  assign probe     = flags.searching ? signed'(probe_raw) : '0;

endmodule

// ----- sv/golden_section_bracket_search_core.sv -----
// ----------------------------------------------------------------------------
// golden_section_bracket_search_core
// Golden-section minimizer over a three-point bracket in signed fixed point;
// the function itself is evaluated outside and returned as probe values.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Direction  Carries
//   input    in_valid / in_stall  in         operation, start bracket, probe value
//   output   out_valid/out_stall  out        probe, done flag, best point, bounds
//   config   APB psel/penable     in         three tolerance registers
//
// A word is accepted into an input register, then processed and written to the
// result register; one word can be taken every cycle while the output does not
// stall. That rate is set by the combinational loop from the bracket registers
// through the update, the golden-ratio multiplier and back.
// Reset is synchronous and clears the bracket, the search status and the
// tolerances to their defaults. A stalled result holds the result register;
// the input register then holds too and in_stall rises while it is full.
module golden_section_bracket_search_core #(
  parameter int DATA_WIDTH = gsbs_pkg::DEF_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic signed [DATA_WIDTH-1:0]         start_left,
  input  logic signed [DATA_WIDTH-1:0]         start_middle,
  input  logic signed [DATA_WIDTH-1:0]         start_right,
  input  logic signed [DATA_WIDTH-1:0]         start_left_value,
  input  logic signed [DATA_WIDTH-1:0]         start_middle_value,
  input  logic signed [DATA_WIDTH-1:0]         start_right_value,
  input  logic signed [DATA_WIDTH-1:0]         probe_value,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [DATA_WIDTH-1:0]         probe_position,
  output logic                                 done_res,
  output logic signed [DATA_WIDTH-1:0]         best_position,
  output logic signed [DATA_WIDTH-1:0]         best_value,
  output logic signed [DATA_WIDTH-1:0]         left_bound,
  output logic signed [DATA_WIDTH-1:0]         right_bound,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gsbs_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [gsbs_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [gsbs_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready
);

  gsbs_pkg::cfg_t cfg;

  // Input register.
  logic                         a_valid;
  logic                         a_op;
  logic signed [DATA_WIDTH-1:0] a_start_pos [3];
  logic signed [DATA_WIDTH-1:0] a_start_val [3];
  logic signed [DATA_WIDTH-1:0] a_probe_value;

  // Search state.
  logic signed [DATA_WIDTH-1:0] pos [3];
  logic signed [DATA_WIDTH-1:0] val [3];
  logic signed [DATA_WIDTH-1:0] probe_point;
  gsbs_pkg::flags_t             flags;

  // Next-state logic outputs.
  logic signed [DATA_WIDTH-1:0] pos_next [3];
  logic signed [DATA_WIDTH-1:0] val_next [3];
  logic signed [DATA_WIDTH-1:0] probe_next;
  gsbs_pkg::flags_t             flags_next;
  logic                         idle_probe;

  logic o_valid;
  logic advance;
  logic in_take;

  gsbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The stored word moves on whenever the result register is empty or is
  // being emptied in this same cycle.
  assign advance   = a_valid && (!o_valid || !out_stall);
  assign in_stall  = a_valid && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op           <= operation;
      a_start_pos[0] <= start_left;
      a_start_pos[1] <= start_middle;
      a_start_pos[2] <= start_right;
      a_start_val[0] <= start_left_value;
      a_start_val[1] <= start_middle_value;
      a_start_val[2] <= start_right_value;
      a_probe_value  <= probe_value;
    end
  end

  gsbs_update #(.DATA_WIDTH(DATA_WIDTH)) u_update (
    .operation   (a_op),
    .start_pos   (a_start_pos),
    .start_val   (a_start_val),
    .probe_value (a_probe_value),
    .pos_cur     (pos),
    .val_cur     (val),
    .probe_point (probe_point),
    .flags_cur   (flags),
    .pos_next    (pos_next),
    .val_next    (val_next),
    .idle_probe  (idle_probe)
  );

  gsbs_decide #(.DATA_WIDTH(DATA_WIDTH)) u_decide (
    .pos   (pos_next),
    .cfg   (cfg),
    .probe (probe_next),
    .flags (flags_next)
  );

  // Bracket state. A probe value that arrives while no search is running
  // leaves everything as it is.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '{default: '0};
      val         <= '{default: '0};
      probe_point <= '0;
      flags       <= '0;
    end else if (advance && !idle_probe) begin
      pos         <= pos_next;
      val         <= val_next;
      probe_point <= probe_next;
      flags       <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (!out_stall) begin
      o_valid <= 1'b0;
    end
  end

  // Result register. An idle probe repeats the done result for the bracket
  // currently held, without a fresh convergence test.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (idle_probe) begin
        probe_position <= '0;
        done_res       <= 1'b1;
        best_position  <= pos[1];
        best_value     <= val[1];
        left_bound     <= pos[0];
        right_bound    <= pos[2];
      end else begin
        probe_position <= probe_next;
        done_res       <= !flags_next.searching;
        best_position  <= pos_next[1];
        best_value     <= val_next[1];
        left_bound     <= pos_next[0];
        right_bound    <= pos_next[2];
      end
    end
  end

  // The bracket stays ordered after every word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_bound <= best_position) && (best_position <= right_bound))
    else $error("result bracket is out of order");

  // A pending probe always lies inside the reported bracket.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |->
      (left_bound <= probe_position) && (probe_position <= right_bound))
    else $error("probe lies outside the bracket");

  // A converged result carries no probe.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> probe_position == '0)
    else $error("done result with nonzero probe");

  // A word leaving the input register always shows up as a result.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed word produced no result");

  // The stored search status matches the last non-idle result.
  assert property (@(posedge clk) disable iff (rst)
    advance && !idle_probe |=> flags.searching == !done_res)
    else $error("search status disagrees with result");

endmodule

// ----- verif/golden_section_bracket_search_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golden_section_bracket_search_core_tb
// Self-checking bench for the golden-section bracket search core. Searches
// over a shifted absolute-value cost are played against a local predictor of
// the bracket update, under several tolerance settings and handshake mixes.
// ----------------------------------------------------------------------------
module golden_section_bracket_search_core_tb;

  localparam int DW = gsbs_pkg::DEF_DATA_WIDTH;
  localparam longint WORD_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) <<< (DW - 1));
  localparam logic [DW-1:0] WMAX = DW'(WORD_MAX);
  localparam logic [DW-1:0] WMIN = DW'(WORD_MIN);
  // One address past the last tolerance register; writes there are dropped.
  localparam int REG_BEYOND = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS = 6_000_000;

  // One input word as the sender presents it.
  typedef struct packed {
    gsbs_pkg::op_t      op;
    logic [2:0][DW-1:0] spos;
    logic [2:0][DW-1:0] sval;
    logic [DW-1:0]      pval;
  } search_word_t;

  // Bracket state: sorted positions, their values, the pending probe.
  typedef struct packed {
    logic [2:0][DW-1:0] pos;
    logic [2:0][DW-1:0] val;
    logic [DW-1:0]      probe_pt;
    gsbs_pkg::flags_t   flags;
  } bracket_t;

  typedef struct packed {
    logic [DW-1:0] probe_position;
    logic          done;
    logic [DW-1:0] best_position;
    logic [DW-1:0] best_value;
    logic [DW-1:0] left_bound;
    logic [DW-1:0] right_bound;
  } search_out_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          operation = 1'b0;
  logic [DW-1:0] start_left = '0;
  logic [DW-1:0] start_middle = '0;
  logic [DW-1:0] start_right = '0;
  logic [DW-1:0] start_left_value = '0;
  logic [DW-1:0] start_middle_value = '0;
  logic [DW-1:0] start_right_value = '0;
  logic [DW-1:0] probe_value = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DW-1:0] probe_position;
  logic          done_res;
  logic [DW-1:0] best_position;
  logic [DW-1:0] best_value;
  logic [DW-1:0] left_bound;
  logic [DW-1:0] right_bound;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [gsbs_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [gsbs_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [gsbs_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic                                pready;

  // Words waiting for the driver, and results the block still owes us.
  search_word_t word_queue[$];
  search_out_t  expected_results[$];
  search_word_t offered;

  // Tolerances as currently programmed. The planner copy of the bracket is
  // advanced as words are queued, the checker copy as they are accepted.
  gsbs_pkg::cfg_t cfg_now = '{gsbs_pkg::REL_TOL_RESET, gsbs_pkg::MIN_REL_TOL_RESET,
                              gsbs_pkg::ABS_TOL_RESET};
  bracket_t plan_state = '0;
  bracket_t model_state = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_rx = 1'b0;

  int error_count = 0;
  int words_planned = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int brackets_loaded = 0;
  int settings_used = 0;

  golden_section_bracket_search_core #(.DATA_WIDTH(DW)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .start_left(start_left), .start_middle(start_middle), .start_right(start_right),
    .start_left_value(start_left_value), .start_middle_value(start_middle_value),
    .start_right_value(start_right_value), .probe_value(probe_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .probe_position(probe_position), .done_res(done_res),
    .best_position(best_position), .best_value(best_value),
    .left_bound(left_bound), .right_bound(right_bound),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Next bracket after one word. A start loads and sorts the triple; a probe
  // value shrinks the bracket only while a search is running, otherwise the
  // state stays as it is. After any change the stop test is redone and, if
  // the bracket is still too wide, the next probe is placed.
  function automatic bracket_t advance_bracket(bracket_t s, gsbs_pkg::cfg_t c,
                                               search_word_t w);
    bracket_t n;
    logic [DW-1:0] t, width, ab, bc, mag;
    logic [gsbs_pkg::TOL_WIDTH-1:0] tol;
    logic [63:0] thr, prod;
    logic below;
    int r, k;
    n = s;
    if (w.op == gsbs_pkg::OP_START) begin
      n.pos = w.spos;
      n.val = w.sval;
      // Compare-and-swap on pairs 0/1, 1/2, 0/1; equal positions keep order.
      for (r = 0; r < 3; r++) begin
        k = (r == 1) ? 1 : 0;
        if ($signed(n.pos[k]) > $signed(n.pos[k+1])) begin
          t = n.pos[k]; n.pos[k] = n.pos[k+1]; n.pos[k+1] = t;
          t = n.val[k]; n.val[k] = n.val[k+1]; n.val[k+1] = t;
        end
      end
    end else if (n.flags.searching) begin
      below = $signed(w.pval) < $signed(n.val[1]);
      if (below) begin
        // The probe takes the middle and the old middle becomes the outer
        // point on the side away from the probe.
        if (n.flags.on_right) begin
          n.pos[0] = n.pos[1]; n.val[0] = n.val[1];
        end else begin
          n.pos[2] = n.pos[1]; n.val[2] = n.val[1];
        end
        n.pos[1] = n.probe_pt;
        n.val[1] = w.pval;
      end else if (n.flags.on_right) begin
        n.pos[2] = n.probe_pt; n.val[2] = w.pval;
      end else begin
        n.pos[0] = n.probe_pt; n.val[0] = w.pval;
      end
    end else begin
      return n;
    end
    width = n.pos[2] - n.pos[0];
    mag = n.pos[1][DW-1] ? (~n.pos[1] + 1'b1) : n.pos[1];
    tol = (c.rel_tolerance > c.min_rel_tolerance) ? c.rel_tolerance : c.min_rel_tolerance;
    thr = (64'(mag) * 64'(tol)) >> 16;
    if (64'(c.abs_tolerance) > thr) thr = 64'(c.abs_tolerance);
    if (64'(width) > thr) begin
      ab = n.pos[1] - n.pos[0];
      bc = n.pos[2] - n.pos[1];
      // The right side is taken only when strictly wider.
      n.flags.on_right = bc > ab;
      prod = 64'(n.flags.on_right ? bc : ab) * 64'(gsbs_pkg::GOLD_Q32);
      t = prod[63:32] + prod[31];
      n.probe_pt = n.flags.on_right ? n.pos[1] + t : n.pos[1] - t;
      n.flags.searching = 1'b1;
    end else begin
      n.flags.searching = 1'b0;
    end
    return n;
  endfunction

  function automatic search_out_t search_report(bracket_t s);
    search_out_t r;
    r.probe_position = s.flags.searching ? s.probe_pt : '0;
    r.done = !s.flags.searching;
    r.best_position = s.pos[1];
    r.best_value = s.val[1];
    r.left_bound = s.pos[0];
    r.right_bound = s.pos[2];
    return r;
  endfunction

  function automatic logic [DW-1:0] clamp_word(longint v);
    if (v > WORD_MAX) return WMAX;
    if (v < WORD_MIN) return WMIN;
    return v[DW-1:0];
  endfunction

  // The function being minimized: distance to a target plus an offset.
  function automatic logic [DW-1:0] cost_at(logic [DW-1:0] x, longint target, longint bias);
    longint d;
    d = longint'($signed(x)) - target;
    if (d < 0) d = -d;
    return clamp_word(d + bias);
  endfunction

  // Start words carry a random probe value, probe words random start fields,
  // so that the ignored fields toggle as well.
  function automatic search_word_t start_word(logic [DW-1:0] p0, p1, p2, v0, v1, v2);
    search_word_t w;
    w.op = gsbs_pkg::OP_START;
    w.spos[0] = p0; w.spos[1] = p1; w.spos[2] = p2;
    w.sval[0] = v0; w.sval[1] = v1; w.sval[2] = v2;
    w.pval = $urandom;
    return w;
  endfunction

  function automatic search_word_t probe_word(logic [DW-1:0] pv);
    search_word_t w;
    int j;
    w.op = gsbs_pkg::OP_PROBE;
    for (j = 0; j < 3; j++) begin
      w.spos[j] = $urandom;
      w.sval[j] = $urandom;
    end
    w.pval = pv;
    return w;
  endfunction

  task automatic push_word(search_word_t w);
    word_queue.push_back(w);
    plan_state = advance_bracket(plan_state, cfg_now, w);
    words_planned++;
    if (w.op == gsbs_pkg::OP_START) brackets_loaded++;
  endtask

  // One search: a start word, then the cost at each probe until the bracket
  // converges. A few probe values are noise, a few searches are cut short by
  // the next start, and some end with a stray probe value while idle.
  task automatic queue_one_search();
    logic [2:0][DW-1:0] pts, vals;
    longint target, bias, mid;
    int perm[3];
    int rot, steps, j;
    bit flip;
    logic [DW-1:0] pv;
    target = longint'(int'($urandom)) >>> $urandom_range(0, 24);
    bias = longint'(int'($urandom)) >>> $urandom_range(2, 31);
    if ($urandom_range(0, 99) < 15) begin
      // Arbitrary triple: unordered, not bracketing, every bit free.
      for (j = 0; j < 3; j++) begin
        pts[j] = $urandom;
        vals[j] = $urandom;
      end
    end else begin
      mid = target + (longint'(int'($urandom)) >>> $urandom_range(12, 31));
      pts[0] = clamp_word(target - (longint'($urandom) >> $urandom_range(0, 31)));
      pts[1] = clamp_word(mid);
      pts[2] = clamp_word(target + (longint'($urandom) >> $urandom_range(0, 31)));
      for (j = 0; j < 3; j++) vals[j] = cost_at(pts[j], target, bias);
    end
    // Present the triple in a random order; the block has to sort it.
    rot = $urandom_range(0, 2);
    flip = $urandom_range(0, 1);
    for (j = 0; j < 3; j++) perm[j] = (rot + (flip ? 2 - j : j)) % 3;
    push_word(start_word(pts[perm[0]], pts[perm[1]], pts[perm[2]],
                         vals[perm[0]], vals[perm[1]], vals[perm[2]]));
    steps = 0;
    while (plan_state.flags.searching && steps < 80) begin
      if ($urandom_range(0, 99) < 2) break;
      if ($urandom_range(0, 99) < 4) pv = $urandom;
      else pv = cost_at(plan_state.probe_pt, target, bias);
      push_word(probe_word(pv));
      steps++;
    end
    if ($urandom_range(0, 99) < 10) push_word(probe_word($urandom));
  endtask

  task automatic queue_searches(int count);
    int goal;
    goal = words_planned + count;
    while (words_planned < goal) queue_one_search();
  endtask

  // APB write: setup cycle, then access cycle until pready is seen high.
  task automatic write_reg(int idx, logic [gsbs_pkg::TOL_WIDTH-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= gsbs_pkg::APB_ADDR_WIDTH'(4 * idx);
    pwdata <= gsbs_pkg::APB_DATA_WIDTH'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gsbs_pkg::REG_REL_TOL:     cfg_now.rel_tolerance = value;
      gsbs_pkg::REG_MIN_REL_TOL: cfg_now.min_rel_tolerance = value;
      gsbs_pkg::REG_ABS_TOL:     cfg_now.abs_tolerance = value;
      default: ;
    endcase
  endtask

  // Sender pause: nothing queued, nothing offered, nothing owed. The extra
  // cycles cover the input and result registers before any register is touched.
  task automatic wait_drained();
    while (word_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Driver. A word is accepted at an edge where in_valid is high and in_stall
  // low; that is when the checker copy of the bracket steps and the expected
  // result is queued. A stalled word is held unchanged; otherwise the next
  // word is offered unless this cycle is picked to idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        model_state = advance_bracket(model_state, cfg_now, offered);
        expected_results.push_back(search_report(model_state));
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (word_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offered = word_queue.pop_front();
          in_valid <= 1'b1;
          operation <= offered.op;
          start_left <= offered.spos[0];
          start_middle <= offered.spos[1];
          start_right <= offered.spos[2];
          start_left_value <= offered.sval[0];
          start_middle_value <= offered.sval[1];
          start_right_value <= offered.sval[2];
          probe_value <= offered.pval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result word taken is compared field by field with the
  // oldest expectation; the stall for the next cycle is drawn afterwards.
  always @(posedge clk) begin
    search_out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t ns: result word with nothing expected", $time);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (probe_position !== want.probe_position)
            report_mismatch("probe_position", want.probe_position, probe_position);
          if (done_res !== want.done)
            report_mismatch("done_res", DW'(want.done), DW'(done_res));
          if (best_position !== want.best_position)
            report_mismatch("best_position", want.best_position, best_position);
          if (best_value !== want.best_value)
            report_mismatch("best_value", want.best_value, best_value);
          if (left_bound !== want.left_bound)
            report_mismatch("left_bound", want.left_bound, left_bound);
          if (right_bound !== want.right_bound)
            report_mismatch("right_bound", want.right_bound, right_bound);
        end
      end
      out_stall <= hold_rx || ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Long receiver hold-off: the output stalls solid while the sender keeps
  // offering, so both pipe stages fill and in_stall has to rise.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    gsbs_pkg::cfg_t next_cfg;
    int p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Loosest tolerances so that a bracket of width two still
    // searches; the write past the last register must change nothing.
    write_reg(gsbs_pkg::REG_REL_TOL, '0);
    write_reg(gsbs_pkg::REG_MIN_REL_TOL, '0);
    write_reg(gsbs_pkg::REG_ABS_TOL, 16'd1);
    write_reg(REG_BEYOND, 16'hFFFF);
    settings_used++;
    // Probe value straight after reset: done, all-zero bracket.
    push_word(probe_word(32'h0000_1234));
    // Equal sides of width one: zero offset, the probe lands on the middle.
    // An equal value then replaces the left point and the search converges.
    push_word(start_word(32'd0, 32'd1, 32'd2, 32'd5, 32'd0, 32'd5));
    push_word(probe_word(32'd0));
    // Converged, so this value is ignored and the done word repeats.
    push_word(probe_word(WMAX));
    // Extreme positions and values, given out of order.
    push_word(start_word(WMAX, WMIN, 32'd0, WMIN, WMAX, 32'd0));
    push_word(probe_word(WMIN));
    push_word(probe_word(WMAX));
    push_word(probe_word(32'd0));
    // All positions equal: zero width, done at once.
    push_word(start_word(32'd7, 32'd7, 32'd7, 32'd1, 32'd2, 32'd3));
    push_word(probe_word(32'd9));
    // Right side strictly wider; a high value, then a new minimum.
    push_word(start_word(-32'sd10, 32'd0, 32'd100, 32'd1, 32'd0, 32'd1));
    push_word(probe_word(WMAX));
    push_word(probe_word(WMIN));
    // Reversed order, values travel with their positions.
    push_word(start_word(32'h0003_0000, 32'h0002_0000, 32'h0001_0000,
                         32'd30, 32'd20, 32'd10));
    push_word(probe_word(32'd20));
    push_word(probe_word(-32'sd1));
    // Duplicate positions keep their relative order through the sort.
    push_word(start_word(32'd5, 32'd5, -32'sd5, 32'd1, 32'd2, 32'd3));
    push_word(probe_word(32'd0));
    wait_drained();

    // Random part: one tolerance setting and one idle mix per phase.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: next_cfg = '{16'd0, 16'd0, 16'd1};
        1: next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: next_cfg = '{gsbs_pkg::REL_TOL_RESET, gsbs_pkg::MIN_REL_TOL_RESET,
                        gsbs_pkg::ABS_TOL_RESET};
        3: next_cfg = '{16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535))};
        4: next_cfg = '{16'($urandom_range(0, 255)), 16'($urandom_range(256, 4095)),
                        16'($urandom_range(1, 255))};
        default: next_cfg = '{16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                               16'($urandom_range(1, 4095))};
      endcase
      write_reg(gsbs_pkg::REG_REL_TOL, next_cfg.rel_tolerance);
      write_reg(gsbs_pkg::REG_MIN_REL_TOL, next_cfg.min_rel_tolerance);
      write_reg(gsbs_pkg::REG_ABS_TOL, next_cfg.abs_tolerance);
      settings_used++;
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      queue_searches(300);
      wait_drained();
    end

    // Back-pressure phase: full-rate sender against a stuck receiver.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_go = 1'b1;
    queue_searches(200);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d results for %0d words: %0d bracket loads, %0d tolerance settings.",
             results_checked, words_accepted, brackets_loaded, settings_used);
    $display("Handshake mixes ran from no idling to heavy stalls plus a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
